// File: rtl/core/mtsp_pkg.sv
package mtsp_pkg;

    // Buffer bound for one partial tag, closing ']' included
    localparam int MAX_TAG_BYTES = 32;
    localparam int ADDR_W        = $clog2(MAX_TAG_BYTES);

    // Tag indexes
    localparam int NUM_TAGS        = 7;
    localparam int TAG_COLOR_OPEN  = 0;
    localparam int TAG_COLOR_CLOSE = 1;
    localparam int TAG_ITALIC_ON   = 2;
    localparam int TAG_ITALIC_OFF  = 3;
    localparam int TAG_BOLD_ON     = 4;
    localparam int TAG_BOLD_OFF    = 5;
    localparam int TAG_BREAK       = 6;

    // Tag text, left-justified: first character in bits 63:56
    localparam logic [NUM_TAGS-1:0][63:0] TAG_TEXT = {
        {"[br]",     32'h0},
        {"[/b]",     32'h0},
        {"[b]",      40'h0},
        {"[/i]",     32'h0},
        {"[i]",      40'h0},
        64'("[/color]"),
        64'("[color:#")
    };
    localparam logic [NUM_TAGS-1:0][3:0] TAG_LEN = {
        4'd4, 4'd4, 4'd3, 4'd4, 4'd3, 4'd8, 4'd8
    };

    // Result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_BREAK = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [7:0] CHAR_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [31:0] MAGENTA_RGBA      = 32'hFF00FFFF;
    localparam logic [31:0] DEFAULT_COLOR_RST = 32'hFFFFFFFF;
    localparam logic [3:0]  HEX_MAX_DIGITS    = 4'd8;

    // Character at position pos of a left-justified tag string
    function automatic logic [7:0] tag_char(input logic [63:0] s, input logic [2:0] pos);
        return s[{3'd7 - pos, 3'b000} +: 8];
    endfunction

    // {valid, value} of an ASCII hex digit
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
        begin
            r = {1'b1, 4'(c - "0")};
        end
        else if (c >= "a" && c <= "f")
        begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end
        else if (c >= "A" && c <= "F")
        begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/markup_tag_stream_parser.sv
// Inline tag stripper. Bytes enter on s_axis one item at a time (tlast marks the last
// byte of a message) and text results leave on m_axis with the current color and
// style. Tags [b] [/b] [i] [/i] [br] [/color] and [color:#RRGGBBAA] are removed; a
// partial tag is held in a 32-byte buffer memory and, when the match breaks, is
// replayed as text. While a partial tag is replayed, input is held off: each
// buffered byte takes a buffer read and then a load of the result register, and
// then the byte that broke the match is handled. One result register sits on the
// output, so a byte is taken while the previous result still waits. default_color
// takes effect at the next [/color] or at the next message.
module markup_tag_stream_parser
    import mtsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // char_out[7:0] red[15:8] green[23:16] blue[31:24] alpha[39:32]
    // italic[40] bold[41], zero fill
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last_result
);

    typedef enum logic [1:0] {ST_IN, ST_READ, ST_EMIT, ST_TAIL} state_t;
    typedef enum logic [1:0] {PH_IDLE, PH_MATCH, PH_BODY} phase_t;
    typedef enum logic [2:0] {TL_NONE, TL_CHAR, TL_BREAK, TL_END, TL_PEND} tail_t;

    // {kind, char} for a trailing result
    function automatic logic [9:0] tail_result(input tail_t t, input logic [7:0] ch);
        logic [9:0] r;
        case (t)
            TL_BREAK: r = {KIND_BREAK, CHAR_LF};
            TL_END:   r = {KIND_END, CHAR_NUL};
            default:  r = {KIND_CHAR, ch};
        endcase
        return r;
    endfunction

    // Pending tag bytes
    logic [7:0]        pend_mem [MAX_TAG_BYTES];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    tail_t             tail_reg, tail_next;
    logic [NUM_TAGS-1:0] cand_reg, cand_next;
    logic [ADDR_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [7:0]        tail_char_reg, tail_char_next;
    logic              eom_reg, eom_next;
    logic [31:0]       default_color_reg, default_color_next;
    logic [31:0]       color_reg, color_next;
    logic              italic_reg, italic_next;
    logic              bold_reg, bold_next;
    logic [31:0]       hex_value_reg, hex_value_next;
    logic [3:0]        hex_digits_reg, hex_digits_next;
    logic              hex_stop_reg, hex_stop_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic [31:0]       out_color_reg, out_color_next;
    logic              out_italic_reg, out_italic_next;
    logic              out_bold_reg, out_bold_next;
    logic              out_last_reg, out_last_next;

    logic [NUM_TAGS-1:0] hit;
    logic [NUM_TAGS-1:0] complete;
    logic [7:0]        c;
    logic              eom;

    assign c   = s_axis_tdata;
    assign eom = s_axis_tlast;

    assign s_axis_tready = (state_reg == ST_IN);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'b0, out_bold_reg, out_italic_reg, out_color_reg[7:0],
                            out_color_reg[15:8], out_color_reg[23:16],
                            out_color_reg[31:24], out_char_reg};

    // Prefix match of the next byte against each still-possible tag
    always_comb
    begin
        for (int k = 0; k < NUM_TAGS; k++)
        begin
            hit[k] = cand_reg[k] && (count_reg < ADDR_W'(TAG_LEN[k]))
                     && (tag_char(TAG_TEXT[k], count_reg[2:0]) == c);
            complete[k] = hit[k] && (count_reg == ADDR_W'(TAG_LEN[k] - 4'd1));
        end
    end

    // Sequencer and state update
    always_comb
    begin
        logic       flush;
        logic       out_free;
        logic       ld;
        logic [9:0] res;
        tail_t      tail;
        logic [4:0] hx;

        state_next         = state_reg;
        phase_next         = phase_reg;
        tail_next          = tail_reg;
        cand_next          = cand_reg;
        count_next         = count_reg;
        idx_next           = idx_reg;
        tail_char_next     = tail_char_reg;
        eom_next           = eom_reg;
        default_color_next = cfg_we ? cfg_wdata : default_color_reg;
        color_next         = color_reg;
        italic_next        = italic_reg;
        bold_next          = bold_reg;
        hex_value_next     = hex_value_reg;
        hex_digits_next    = hex_digits_reg;
        hex_stop_next      = hex_stop_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_kind_next      = out_kind_reg;
        out_char_next      = out_char_reg;
        out_color_next     = out_color_reg;
        out_italic_next    = out_italic_reg;
        out_bold_next      = out_bold_reg;
        out_last_next      = out_last_reg;
        mem_we             = 1'b0;
        mem_waddr          = count_reg;
        mem_wdata          = c;
        flush              = 1'b0;
        tail               = TL_NONE;
        out_free           = !out_valid_reg || m_axis_tready;
        ld                 = 1'b0;
        res                = {KIND_CHAR, c};
        hx                 = hex_of(c);

        case (state_reg)
            ST_IN:
            begin
                if (s_axis_tvalid)
                begin
                    case (phase_reg)
                        PH_MATCH:
                        begin
                            if (hit == '0)
                            begin
                                flush = 1'b1;
                                tail  = (c == CHAR_OPEN && !eom) ? TL_PEND : TL_CHAR;
                            end
                            else if (complete[TAG_COLOR_OPEN] || complete == '0)
                            begin
                                // prefix grows, or color body starts
                                if (eom)
                                begin
                                    flush = 1'b1;
                                    tail  = TL_CHAR;
                                end
                                else
                                begin
                                    mem_we     = 1'b1;
                                    count_next = count_reg + ADDR_W'(1);
                                    cand_next  = hit;
                                    if (complete[TAG_COLOR_OPEN])
                                    begin
                                        phase_next      = PH_BODY;
                                        hex_value_next  = '0;
                                        hex_digits_next = '0;
                                        hex_stop_next   = 1'b0;
                                    end
                                end
                            end
                            else
                            begin
                                // simple tag complete
                                count_next = '0;
                                phase_next = PH_IDLE;
                                tail       = eom ? TL_END : TL_NONE;
                                if (complete[TAG_COLOR_CLOSE])
                                begin
                                    color_next = default_color_reg;
                                end
                                if (complete[TAG_ITALIC_ON])
                                begin
                                    italic_next = 1'b1;
                                end
                                if (complete[TAG_ITALIC_OFF])
                                begin
                                    italic_next = 1'b0;
                                end
                                if (complete[TAG_BOLD_ON])
                                begin
                                    bold_next = 1'b1;
                                end
                                if (complete[TAG_BOLD_OFF])
                                begin
                                    bold_next = 1'b0;
                                end
                                if (complete[TAG_BREAK])
                                begin
                                    tail = TL_BREAK;
                                end
                            end
                        end
                        PH_BODY:
                        begin
                            if (c == CHAR_CLOSE)
                            begin
                                color_next = (hex_digits_reg != '0) ? hex_value_reg
                                                                    : MAGENTA_RGBA;
                                count_next = '0;
                                phase_next = PH_IDLE;
                                tail       = eom ? TL_END : TL_NONE;
                            end
                            else if (eom || count_reg == ADDR_W'(MAX_TAG_BYTES - 1))
                            begin
                                flush = 1'b1;
                                tail  = (c == CHAR_OPEN && !eom) ? TL_PEND : TL_CHAR;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + ADDR_W'(1);
                                if (!hex_stop_reg && hex_digits_reg < HEX_MAX_DIGITS)
                                begin
                                    if (hx[4])
                                    begin
                                        hex_value_next  = {hex_value_reg[27:0], hx[3:0]};
                                        hex_digits_next = hex_digits_reg + 4'd1;
                                    end
                                    else
                                    begin
                                        hex_stop_next = 1'b1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            if (c == CHAR_OPEN && !eom)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                count_next = ADDR_W'(1);
                                phase_next = PH_MATCH;
                                cand_next  = '1;
                            end
                            else
                            begin
                                tail = TL_CHAR;
                            end
                        end
                    endcase

                    tail_char_next = c;
                    eom_next       = eom;
                    if (flush)
                    begin
                        idx_next   = '0;
                        tail_next  = tail;
                        state_next = ST_READ;
                    end
                    else if (tail != TL_NONE)
                    begin
                        if (out_free)
                        begin
                            ld  = 1'b1;
                            res = tail_result(tail, c);
                            out_last_next = eom;
                        end
                        else
                        begin
                            tail_next  = tail;
                            state_next = ST_TAIL;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ld            = 1'b1;
                    res           = {KIND_CHAR, rdata_reg};
                    out_last_next = 1'b0;
                    idx_next      = idx_reg + ADDR_W'(1);
                    state_next    = (idx_reg + ADDR_W'(1) == count_reg) ? ST_TAIL : ST_READ;
                end
            end
            ST_TAIL:
            begin
                if (tail_reg == TL_PEND)
                begin
                    // byte that broke the match opens a new tag
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = CHAR_OPEN;
                    count_next = ADDR_W'(1);
                    phase_next = PH_MATCH;
                    cand_next  = '1;
                    state_next = ST_IN;
                end
                else if (out_free)
                begin
                    ld            = 1'b1;
                    res           = tail_result(tail_reg, tail_char_reg);
                    out_last_next = eom_reg;
                    count_next    = '0;
                    phase_next    = PH_IDLE;
                    state_next    = ST_IN;
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase

        // Load the result register from the updated style
        if (ld)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = res[9:8];
            out_char_next   = res[7:0];
            out_color_next  = color_next;
            out_italic_next = italic_next;
            out_bold_next   = bold_next;
            // end of message: back to defaults after the last result
            if (out_last_next)
            begin
                color_next      = default_color_reg;
                italic_next     = 1'b0;
                bold_next       = 1'b0;
                phase_next      = PH_IDLE;
                count_next      = '0;
                hex_value_next  = '0;
                hex_digits_next = '0;
                hex_stop_next   = 1'b0;
            end
        end
    end

    // Control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IN;
            phase_reg         <= PH_IDLE;
            tail_reg          <= TL_NONE;
            cand_reg          <= '0;
            count_reg         <= '0;
            idx_reg           <= '0;
            eom_reg           <= 1'b0;
            default_color_reg <= DEFAULT_COLOR_RST;
            color_reg         <= DEFAULT_COLOR_RST;
            italic_reg        <= 1'b0;
            bold_reg          <= 1'b0;
            hex_value_reg     <= '0;
            hex_digits_reg    <= '0;
            hex_stop_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            tail_reg          <= tail_next;
            cand_reg          <= cand_next;
            count_reg         <= count_next;
            idx_reg           <= idx_next;
            eom_reg           <= eom_next;
            default_color_reg <= default_color_next;
            color_reg         <= color_next;
            italic_reg        <= italic_next;
            bold_reg          <= bold_next;
            hex_value_reg     <= hex_value_next;
            hex_digits_reg    <= hex_digits_next;
            hex_stop_reg      <= hex_stop_next;
            out_valid_reg     <= out_valid_next;
            out_last_reg      <= out_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tail_char_reg  <= tail_char_next;
        out_kind_reg   <= out_kind_next;
        out_char_reg   <= out_char_next;
        out_color_reg  <= out_color_next;
        out_italic_reg <= out_italic_next;
        out_bold_reg   <= out_bold_next;
    end

    // Buffer memory: written while a tag is matched; registered read of the entry at idx_reg, used while replaying
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pend_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= pend_mem[idx_reg];
    end

endmodule
